/* sv/ptc_pkg.sv */
package ptc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned DIV_STAGES = 32;

    localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [1:0] REG_PRESS_LO  = 2'd1;
    localparam logic [1:0] REG_PRESS_HI  = 2'd2;
    localparam logic [1:0] REG_PRESS_NINE = 2'd3;

    localparam logic [31:0] FINE_OFFSET  = 32'd64000;
    localparam logic [31:0] PRESS_BASE   = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] P1_BIAS      = 32'd32768;
    localparam logic [31:0] SIGN_LIMIT   = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF   = 32'd128;
    localparam logic [19:0] PRESS_MAX    = 20'hFFFFF;

    // calibration words, already extended to 32 bits
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } calib_t;

    // side data that rides along with the divider
    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic               dbl;
        logic               pvalid;
    } side_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        asr = $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

/* sv/ptc_if.sv */
interface ptc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    modport source (output valid, raw_pressure, raw_temperature, input ready);
    modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface ptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_centi;
    logic [19:0]        pressure_pa;
    logic               pressure_valid;
    modport source (output valid, temperature_centi, pressure_pa, pressure_valid,
                    input ready);
    modport sink (input valid, temperature_centi, pressure_pa, pressure_valid,
                  output ready);
endinterface

interface ptc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/pressure_temperature_compensation.sv */
// Barometric pressure and temperature compensation pipeline.
//
// Channels: "in" carries one item of raw_pressure and raw_temperature (20 bits
// each), "out" returns one item per input with temperature_centi (signed,
// 0.01 degree), pressure_pa (saturated to 20 bits) and pressure_valid (clear
// when the derived pressure scale is zero; pressure_pa is then 0). "cfg"
// writes the calibration registers: index 0 temperature words, 1 and 2 the
// low and high pressure words, 3 the ninth pressure word. cfg is always ready.
//
// Throughput: one item per cycle while out is not stalled. The path from acceptance to
// the result showing on out runs through 11 front stages (temperature and scale
// math), 32 divider stages (one quotient bit each) and 3 correction stages,
// the last of which is the output register.
//
// Reset clears all valid bits and the calibration registers to zero. When
// the receiver stalls, the whole pipeline holds and in.ready drops; nothing
// is lost or repeated, and in.ready stays high while the output slot is empty
// or being taken.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    ptc_in_if.sink     in,
    ptc_out_if.source  out,
    ptc_cfg_if.sink    cfg
);

    logic [47:0] temp_cal_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_nine_reg;

    calib_t cal;
    logic   en;

    logic        div_in_valid, div_out_valid;
    logic [31:0] div_dividend, div_divisor, div_quotient;
    side_t       div_in_side, div_out_side;

    // configuration: take a write every cycle, ignore nothing else
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_nine_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TEMP_CAL:   temp_cal_reg   <= cfg.data[47:0];
                REG_PRESS_LO:   press_lo_reg   <= cfg.data;
                REG_PRESS_HI:   press_hi_reg   <= cfg.data;
                REG_PRESS_NINE: press_nine_reg <= cfg.data[15:0];
                default:        press_nine_reg <= press_nine_reg;
            endcase
        end
    end

    // unpack and extend the calibration words
    always_comb
    begin
        cal.t1 = {16'd0, temp_cal_reg[15:0]};
        cal.t2 = sx16(temp_cal_reg[31:16]);
        cal.t3 = sx16(temp_cal_reg[47:32]);
        cal.p1 = {16'd0, press_lo_reg[15:0]};
        cal.p2 = sx16(press_lo_reg[31:16]);
        cal.p3 = sx16(press_lo_reg[47:32]);
        cal.p4 = sx16(press_lo_reg[63:48]);
        cal.p5 = sx16(press_hi_reg[15:0]);
        cal.p6 = sx16(press_hi_reg[31:16]);
        cal.p7 = sx16(press_hi_reg[47:32]);
        cal.p8 = sx16(press_hi_reg[63:48]);
        cal.p9 = sx16(press_nine_reg);
    end

    // advance every stage unless a finished item waits on a stalled receiver
    assign en       = !out.valid || out.ready;
    assign in.ready = en;

    ptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .cal             (cal),
        .in_valid        (in.valid),
        .raw_pressure    (in.raw_pressure),
        .raw_temperature (in.raw_temperature),
        .div_valid       (div_in_valid),
        .div_dividend    (div_dividend),
        .div_divisor     (div_divisor),
        .div_side        (div_in_side)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_in_valid),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .in_side   (div_in_side),
        .out_valid (div_out_valid),
        .quotient  (div_quotient),
        .out_side  (div_out_side)
    );

    ptc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .cal               (cal),
        .in_valid          (div_out_valid),
        .quotient          (div_quotient),
        .in_side           (div_out_side),
        .out_valid         (out.valid),
        .temperature_centi (out.temperature_centi),
        .pressure_pa       (out.pressure_pa),
        .pressure_valid    (out.pressure_valid)
    );

endmodule

/* sv/ptc_front.sv */
module ptc_front
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  calib_t      cal,
    input  logic        in_valid,
    input  logic [19:0] raw_pressure,
    input  logic [19:0] raw_temperature,
    output logic        div_valid,
    output logic [31:0] div_dividend,
    output logic [31:0] div_divisor,
    output side_t       div_side
);

    logic [10:0] vld_reg;

    logic [31:0] a1_reg, d_reg;
    logic [31:0] m1_reg, dd_reg;
    logic [31:0] v1t_reg, e_reg;
    logic [31:0] v1t4_reg, m2_reg;
    logic [31:0] tf_reg;
    logic signed [15:0] tc_reg [6:11];
    logic [31:0] v1p_reg, q_reg;
    logic [31:0] v1p8_reg, sq_reg;
    logic [31:0] ma_reg, mb_reg, mc_reg, md_reg;
    logic [31:0] v2_reg, v1x_reg;
    logic [31:0] m10_reg, n10_reg;
    logic [31:0] scale_reg, pn_reg;
    logic [19:0] ap_reg [1:9];

    logic [31:0] at32, ap32;
    logic [31:0] tc_next;
    logic signed [15:0] tsat_next;
    logic [31:0] v1p_next;

    assign at32 = {12'd0, raw_temperature};

    always_comb
    begin
        tc_next = asr((tf_reg << 2) + tf_reg + ROUND_HALF, 8);
        if ($signed(tc_next) > 32'sd32767)
            tsat_next = 16'sh7FFF;
        else if ($signed(tc_next) < -32'sd32768)
            tsat_next = -16'sh8000;
        else
            tsat_next = tc_next[15:0];
        v1p_next = asr(tf_reg, 1) - FINE_OFFSET;
    end

    assign ap32 = {12'd0, ap_reg[9]};

    // valid bits advance with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[9:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            a1_reg    <= (at32 >> 3) - (cal.t1 << 1);
            d_reg     <= (at32 >> 4) - cal.t1;
            ap_reg[1] <= raw_pressure;
            // stage 2
            m1_reg    <= a1_reg * cal.t2;
            dd_reg    <= d_reg * d_reg;
            // stage 3
            v1t_reg   <= asr(m1_reg, 11);
            e_reg     <= asr(dd_reg, 12);
            // stage 4
            v1t4_reg  <= v1t_reg;
            m2_reg    <= e_reg * cal.t3;
            // stage 5
            tf_reg    <= v1t4_reg + asr(m2_reg, 14);
            // stage 6
            tc_reg[6] <= tsat_next;
            v1p_reg   <= v1p_next;
            q_reg     <= asr(v1p_next, 2);
            // stage 7
            v1p8_reg  <= v1p_reg;
            sq_reg    <= q_reg * q_reg;
            // stage 8
            ma_reg    <= asr(sq_reg, 11) * cal.p6;
            mb_reg    <= v1p8_reg * cal.p5;
            mc_reg    <= cal.p3 * asr(sq_reg, 13);
            md_reg    <= cal.p2 * v1p8_reg;
            // stage 9
            v2_reg    <= asr(ma_reg + (mb_reg << 1), 2) + (cal.p4 << 16);
            v1x_reg   <= asr(asr(mc_reg, 3) + asr(md_reg, 1), 18);
            // stage 10
            m10_reg   <= (P1_BIAS + v1x_reg) * cal.p1;
            n10_reg   <= (PRESS_BASE - ap32) - asr(v2_reg, 12);
            // stage 11
            scale_reg <= asr(m10_reg, 15);
            pn_reg    <= n10_reg * PRESS_SCALE;
            for (int i = 2; i <= 9; i++)
                ap_reg[i] <= ap_reg[i-1];
            for (int i = 7; i <= 11; i++)
                tc_reg[i] <= tc_reg[i-1];
        end
    end

    // below the sign limit divide twice the value, otherwise double afterwards
    always_comb
    begin
        div_valid                  = vld_reg[10];
        div_divisor                = scale_reg;
        div_side.temperature_centi = tc_reg[11];
        div_side.pvalid            = (scale_reg != 32'd0);
        div_side.dbl               = (pn_reg >= SIGN_LIMIT);
        div_dividend               = div_side.dbl ? pn_reg : (pn_reg << 1);
    end

endmodule

/* sv/ptc_div.sv */
module ptc_div
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] quotient,
    output side_t       out_side
);

    // one quotient bit per stage; dq holds remaining dividend bits and quotient
    logic [DIV_STAGES-1:0] vld_reg;
    logic [32:0]           rem_reg  [DIV_STAGES];
    logic [31:0]           dq_reg   [DIV_STAGES];
    logic [31:0]           dvs_reg  [DIV_STAGES];
    side_t                 side_reg [DIV_STAGES];

    logic [32:0] rem_next [DIV_STAGES];
    logic [31:0] dq_next  [DIV_STAGES];

    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            logic [32:0] r;
            logic [31:0] q;
            logic [31:0] dv;
            if (k == 0)
            begin
                r  = 33'd0;
                q  = dividend;
                dv = divisor;
            end
            else
            begin
                r  = rem_reg[k-1];
                q  = dq_reg[k-1];
                dv = dvs_reg[k-1];
            end
            r = {r[31:0], q[31]};
            q = {q[30:0], 1'b0};
            if (r >= {1'b0, dv})
            begin
                r    = r - {1'b0, dv};
                q[0] = 1'b1;
            end
            rem_next[k] = r;
            dq_next[k]  = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dq_reg[k]  <= dq_next[k];
                dvs_reg[k] <= (k == 0) ? divisor : dvs_reg[k-1];
                side_reg[k] <= (k == 0) ? in_side : side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quotient  = dq_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

/* sv/ptc_back.sv */
module ptc_back
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  calib_t             cal,
    input  logic               in_valid,
    input  logic [31:0]        quotient,
    input  side_t              in_side,
    output logic               out_valid,
    output logic signed [15:0] temperature_centi,
    output logic [19:0]        pressure_pa,
    output logic               pressure_valid
);

    logic [2:0]  vld_reg;
    logic [31:0] p1_reg, p2_reg;
    logic [31:0] sqy_reg, m8a_reg, m8b_reg, m9_reg;
    side_t       s1_reg, s2_reg;
    logic signed [15:0] tout_reg;
    logic [19:0] pout_reg;
    logic        pv_reg;

    logic [31:0] p_next, r_next, y0;
    logic [19:0] sat_next;

    always_comb
    begin
        p_next = in_side.dbl ? (quotient << 1) : quotient;
        y0     = p_next >> 3;
        r_next = p2_reg + asr(asr(m9_reg, 12) + asr(m8b_reg, 13) + cal.p7, 4);
        sat_next = (r_next > {12'd0, PRESS_MAX}) ? PRESS_MAX : r_next[19:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p_next;
            sqy_reg  <= y0 * y0;
            m8a_reg  <= (p_next >> 2) * cal.p8;
            s1_reg   <= in_side;
            p2_reg   <= p1_reg;
            m9_reg   <= cal.p9 * (sqy_reg >> 13);
            m8b_reg  <= m8a_reg;
            s2_reg   <= s1_reg;
            tout_reg <= s2_reg.temperature_centi;
            pout_reg <= s2_reg.pvalid ? sat_next : 20'd0;
            pv_reg   <= s2_reg.pvalid;
        end
    end

    assign out_valid         = vld_reg[2];
    assign temperature_centi = tout_reg;
    assign pressure_pa       = pout_reg;
    assign pressure_valid    = pv_reg;

endmodule
